// ===== design/svg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package svg_pkg;

   // Grid index clamp applied to both slice and stack indices
   localparam int MAX_DIVISIONS = 1024;

   localparam int INDEX_W    = 11;
   localparam int ANGLE_W    = 16;
   localparam int RADIUS_W   = 16;
   localparam int TEX_W      = 17;
   localparam int NORM_W     = 16;
   localparam int POS_W      = 17;
   localparam int MAG_W      = 15;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 17;

   localparam logic [TEX_W-1:0]   TEX_ONE     = 17'd65536;
   localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'd16384;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_RADIUS     = 3'd0,
      CSR_THETA_STEP = 3'd1,
      CSR_PHI_STEP   = 3'd2,
      CSR_TEX_S_STEP = 3'd3,
      CSR_TEX_T_STEP = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [RADIUS_W-1:0] radius;
      logic [ANGLE_W-1:0]  theta_step;
      logic [ANGLE_W-1:0]  phi_step;
      logic [TEX_W-1:0]    tex_s_step;
      logic [TEX_W-1:0]    tex_t_step;
   } csr_type;

   // Load enables for the two stages inside a sine/cosine unit
   typedef struct packed {
      logic addr_en;
      logic rd_en;
   } stage_en_type;

endpackage

`default_nettype wire

// ===== design/svg_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none

module svg_csr import svg_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_ADDR_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output csr_type                    regs
);

   csr_type regs_ff;
   csr_type regs_in;

   always_comb begin
      regs_in = regs_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_RADIUS:     regs_in.radius     = csr_wdata[RADIUS_W-1:0];
            CSR_THETA_STEP: regs_in.theta_step = csr_wdata[ANGLE_W-1:0];
            CSR_PHI_STEP:   regs_in.phi_step   = csr_wdata[ANGLE_W-1:0];
            CSR_TEX_S_STEP: regs_in.tex_s_step = csr_wdata[TEX_W-1:0];
            CSR_TEX_T_STEP: regs_in.tex_t_step = csr_wdata[TEX_W-1:0];
            default:        regs_in = regs_ff; // drop writes past the map
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.radius     <= 16'd256;
         regs_ff.theta_step <= 16'd4096;
         regs_ff.phi_step   <= 16'd2048;
         regs_ff.tex_s_step <= 17'd4096;
         regs_ff.tex_t_step <= 17'd4096;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign csr_ready = 1'b1;
   assign regs      = regs_ff;

endmodule

`default_nettype wire

// ===== design/svg_sine_rom.sv =====
`timescale 1ns / 1ps
`default_nettype none

module svg_sine_rom import svg_pkg::*; #(
   parameter int SINE_TABLE_DEPTH = 1024,
   localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             rd_en,
   input  wire logic [IDX_W-1:0] addr_a,
   input  wire logic [IDX_W-1:0] addr_b,
   output logic [MAG_W-1:0]      data_a,
   output logic [MAG_W-1:0]      data_b
);

   typedef logic [SINE_TABLE_DEPTH:0][MAG_W-1:0] rom_type;

   localparam logic [63:0] HALF_PI_Q30 = 64'h6487ED51;
   localparam logic [63:0] DEPTH_L     = 64'(SINE_TABLE_DEPTH);
   localparam logic [63:0] STEP_Q      = HALF_PI_Q30 / DEPTH_L;
   localparam logic [63:0] STEP_R      = HALF_PI_Q30 % DEPTH_L;

   function automatic logic [63:0] taylor_div(logic [63:0] t, int n);
      case (n)
         1:       return t / 64'd6;
         2:       return t / 64'd20;
         3:       return t / 64'd42;
         4:       return t / 64'd72;
         5:       return t / 64'd110;
         6:       return t / 64'd156;
         7:       return t / 64'd210;
         8:       return t / 64'd272;
         default: return t;
      endcase
   endfunction

   // Quarter-wave sine in Q1.14 from a nine-term Taylor series in Q30
   function automatic rom_type build_rom();
      rom_type     rom;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] v;
      rom = '0;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         x    = STEP_Q * 64'(k) + (STEP_R * 64'(k)) / DEPTH_L;
         x2   = (x * x) >> 30;
         term = x;
         sum  = x;
         for (int n = 1; n <= 8; n++) begin
            term = taylor_div((term * x2) >> 30, n);
            if ((n & 1) == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         v = (sum + 64'd32768) >> 16;
         if (v > 64'd16384) begin
            v = 64'd16384;
         end
         rom[k] = v[MAG_W-1:0];
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [MAG_W-1:0] data_a_ff;
   logic [MAG_W-1:0] data_b_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_a_ff <= SINE_ROM[addr_a];
         data_b_ff <= SINE_ROM[addr_b];
      end
   end

   assign data_a = data_a_ff;
   assign data_b = data_b_ff;

endmodule

`default_nettype wire

// ===== design/svg_sincos.sv =====
`timescale 1ns / 1ps
`default_nettype none

module svg_sincos import svg_pkg::*; #(
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  wire logic               clock,
   input  wire stage_en_type       en,
   input  wire logic [ANGLE_W-1:0] angle,
   output logic [MAG_W-1:0]        sin_mag,
   output logic                    sin_neg,
   output logic [MAG_W-1:0]        cos_mag,
   output logic                    cos_neg
);

   localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int PROD_W = IDX_W + 15;

   // Returns {negate, table index}: odd quadrants mirror, upper half negates
   function automatic logic [IDX_W:0] lookup_addr(logic [ANGLE_W-1:0] a);
      logic [PROD_W-1:0] prod;
      logic [IDX_W-1:0]  idx;
      prod = PROD_W'(a[13:0]) * PROD_W'(SINE_TABLE_DEPTH) + PROD_W'(14'd8192);
      idx  = prod[14 +: IDX_W];
      if (a[14]) begin
         idx = IDX_W'(SINE_TABLE_DEPTH) - idx;
      end
      return {a[15], idx};
   endfunction

   logic [IDX_W:0]   sin_addr_in;
   logic [IDX_W:0]   cos_addr_in;
   logic [IDX_W-1:0] sin_addr_ff;
   logic [IDX_W-1:0] cos_addr_ff;
   logic             sin_neg2_ff;
   logic             cos_neg2_ff;
   logic             sin_neg3_ff;
   logic             cos_neg3_ff;

   assign sin_addr_in = lookup_addr(angle);
   assign cos_addr_in = lookup_addr(angle + QUARTER_TURN);

   always_ff @(posedge clock) begin
      if (en.addr_en) begin
         sin_addr_ff <= sin_addr_in[IDX_W-1:0];
         cos_addr_ff <= cos_addr_in[IDX_W-1:0];
         sin_neg2_ff <= sin_addr_in[IDX_W];
         cos_neg2_ff <= cos_addr_in[IDX_W];
      end
      if (en.rd_en) begin
         sin_neg3_ff <= sin_neg2_ff;
         cos_neg3_ff <= cos_neg2_ff;
      end
   end

   svg_sine_rom #(
      .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
   ) u_rom (
      .clock  (clock),
      .rd_en  (en.rd_en),
      .addr_a (sin_addr_ff),
      .addr_b (cos_addr_ff),
      .data_a (sin_mag),
      .data_b (cos_mag)
   );

   assign sin_neg = sin_neg3_ff;
   assign cos_neg = cos_neg3_ff;

endmodule

`default_nettype wire

// ===== design/sphere_vertex_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// UV sphere vertex generator.
// Request channel (req_*): one grid point per word, slice and stack index;
// indices above the grid size are clamped. Response channel (rsp_*): one
// vertex per word, position in Q8.8, unit normal in Q1.14 and texture
// coordinates in Q1.16 saturated at 1.0. Register port (csr_*): radius,
// azimuth step, polar step and the two texture steps; always ready, write
// only while no request is in flight.
// Throughput: one word per cycle while the receiver takes words; the five
// stages are angle multiply, table address, sine ROM read (registered read
// data), normal multiply and position multiply.
// Reset: pipeline valid bits clear and registers take their defaults; the
// sine ROM is constant, so no clearing pass and no wait after reset.
// Receiver stall: the output register holds its word, bubbles further back
// close up, and req_ready drops only once all five stages hold a word.

module sphere_vertex_generator import svg_pkg::*; #(
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [INDEX_W-1:0]       req_slice_index,
   input  wire logic [INDEX_W-1:0]       req_stack_index,
   // response
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [POS_W-1:0]       rsp_pos_x,
   output logic signed [POS_W-1:0]       rsp_pos_y,
   output logic signed [POS_W-1:0]       rsp_pos_z,
   output logic signed [NORM_W-1:0]      rsp_norm_x,
   output logic signed [NORM_W-1:0]      rsp_norm_y,
   output logic signed [NORM_W-1:0]      rsp_norm_z,
   output logic [TEX_W-1:0]              rsp_tex_s,
   output logic [TEX_W-1:0]              rsp_tex_t,
   // registers
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_ADDR_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_wdata
);

   csr_type regs;

   svg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .regs      (regs)
   );

   // ------------------------------------------------------------------
   // Pipeline control: a stage loads when it is empty or its word moves on
   // ------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic en1, en2, en3, en4, en5;

   assign en5 = !v5_ff || rsp_ready;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   assign req_ready = en1;
   assign rsp_valid = v5_ff;

   // ------------------------------------------------------------------
   // Stage 1: clamp indices, form angles (wrap to one turn) and texture
   // ------------------------------------------------------------------
   localparam int CLAMP_W = 14;
   localparam int TEXP_W  = INDEX_W + TEX_W;

   logic [INDEX_W-1:0] si_clamp;
   logic [INDEX_W-1:0] ti_clamp;
   logic [TEXP_W-1:0]  s_prod;
   logic [TEXP_W-1:0]  t_prod;
   logic [ANGLE_W-1:0] theta_in, phi_in;
   logic [TEX_W-1:0]   tex_s1_in, tex_t1_in;
   logic [ANGLE_W-1:0] theta1_ff, phi1_ff;
   logic [TEX_W-1:0]   tex_s1_ff, tex_t1_ff;

   assign si_clamp = (CLAMP_W'(req_slice_index) > CLAMP_W'(MAX_DIVISIONS)) ?
                     INDEX_W'(MAX_DIVISIONS) : req_slice_index;
   assign ti_clamp = (CLAMP_W'(req_stack_index) > CLAMP_W'(MAX_DIVISIONS)) ?
                     INDEX_W'(MAX_DIVISIONS) : req_stack_index;

   assign theta_in = ANGLE_W'(si_clamp * regs.theta_step);
   assign phi_in   = ANGLE_W'(ti_clamp * regs.phi_step);
   assign s_prod   = TEXP_W'(si_clamp) * TEXP_W'(regs.tex_s_step);
   assign t_prod   = TEXP_W'(ti_clamp) * TEXP_W'(regs.tex_t_step);

   // saturate at 1.0
   assign tex_s1_in = (s_prod > TEXP_W'(TEX_ONE)) ? TEX_ONE : s_prod[TEX_W-1:0];
   assign tex_t1_in = (t_prod > TEXP_W'(TEX_ONE)) ? TEX_ONE : t_prod[TEX_W-1:0];

   always_ff @(posedge clock) begin
      if (en1) begin
         theta1_ff <= theta_in;
         phi1_ff   <= phi_in;
         tex_s1_ff <= tex_s1_in;
         tex_t1_ff <= tex_t1_in;
      end
   end

   // ------------------------------------------------------------------
   // Stages 2 and 3: table address, then sine ROM read
   // ------------------------------------------------------------------
   stage_en_type     sc_en;
   logic [MAG_W-1:0] st_mag, ct_mag, sp_mag, cp_mag;
   logic             st_neg, ct_neg, sp_neg, cp_neg;
   logic [TEX_W-1:0] tex_s2_ff, tex_t2_ff, tex_s3_ff, tex_t3_ff;

   assign sc_en.addr_en = en2;
   assign sc_en.rd_en   = en3;

   svg_sincos #(
      .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
   ) u_theta (
      .clock   (clock),
      .en      (sc_en),
      .angle   (theta1_ff),
      .sin_mag (st_mag),
      .sin_neg (st_neg),
      .cos_mag (ct_mag),
      .cos_neg (ct_neg)
   );

   svg_sincos #(
      .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
   ) u_phi (
      .clock   (clock),
      .en      (sc_en),
      .angle   (phi1_ff),
      .sin_mag (sp_mag),
      .sin_neg (sp_neg),
      .cos_mag (cp_mag),
      .cos_neg (cp_neg)
   );

   always_ff @(posedge clock) begin
      if (en2) begin
         tex_s2_ff <= tex_s1_ff;
         tex_t2_ff <= tex_t1_ff;
      end
      if (en3) begin
         tex_s3_ff <= tex_s2_ff;
         tex_t3_ff <= tex_t2_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: normal as sign and magnitude, products rounded half away
   // from zero
   // ------------------------------------------------------------------
   localparam int NPROD_W = 2 * MAG_W;

   logic [NPROD_W-1:0] nx_prod, ny_prod;
   logic [MAG_W-1:0]   nx_mag4_ff, ny_mag4_ff, nz_mag4_ff;
   logic               nx_neg4_ff, ny_neg4_ff, nz_neg4_ff;
   logic [TEX_W-1:0]   tex_s4_ff, tex_t4_ff;

   assign nx_prod = NPROD_W'(ct_mag) * NPROD_W'(sp_mag) + NPROD_W'(14'd8192);
   assign ny_prod = NPROD_W'(st_mag) * NPROD_W'(sp_mag) + NPROD_W'(14'd8192);

   always_ff @(posedge clock) begin
      if (en4) begin
         nx_mag4_ff <= nx_prod[14 +: MAG_W];
         ny_mag4_ff <= ny_prod[14 +: MAG_W];
         nz_mag4_ff <= cp_mag;
         nx_neg4_ff <= ct_neg ^ sp_neg;
         ny_neg4_ff <= st_neg ^ sp_neg;
         nz_neg4_ff <= cp_neg;
         tex_s4_ff  <= tex_s3_ff;
         tex_t4_ff  <= tex_t3_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: position = normal * radius, output register
   // ------------------------------------------------------------------
   localparam int PPROD_W = MAG_W + RADIUS_W + 1;

   logic [PPROD_W-1:0]       px_prod, py_prod, pz_prod;
   logic signed [POS_W-1:0]  pos_x_in, pos_y_in, pos_z_in;
   logic signed [NORM_W-1:0] norm_x_in, norm_y_in, norm_z_in;
   logic signed [POS_W-1:0]  pos_x_ff, pos_y_ff, pos_z_ff;
   logic signed [NORM_W-1:0] norm_x_ff, norm_y_ff, norm_z_ff;
   logic [TEX_W-1:0]         tex_s_ff, tex_t_ff;

   assign px_prod = PPROD_W'(nx_mag4_ff) * PPROD_W'(regs.radius) + PPROD_W'(14'd8192);
   assign py_prod = PPROD_W'(ny_mag4_ff) * PPROD_W'(regs.radius) + PPROD_W'(14'd8192);
   assign pz_prod = PPROD_W'(nz_mag4_ff) * PPROD_W'(regs.radius) + PPROD_W'(14'd8192);

   assign pos_x_in = nx_neg4_ff ? -$signed(px_prod[14 +: POS_W]) : $signed(px_prod[14 +: POS_W]);
   assign pos_y_in = ny_neg4_ff ? -$signed(py_prod[14 +: POS_W]) : $signed(py_prod[14 +: POS_W]);
   assign pos_z_in = nz_neg4_ff ? -$signed(pz_prod[14 +: POS_W]) : $signed(pz_prod[14 +: POS_W]);

   assign norm_x_in = nx_neg4_ff ? -$signed({1'b0, nx_mag4_ff}) : $signed({1'b0, nx_mag4_ff});
   assign norm_y_in = ny_neg4_ff ? -$signed({1'b0, ny_mag4_ff}) : $signed({1'b0, ny_mag4_ff});
   assign norm_z_in = nz_neg4_ff ? -$signed({1'b0, nz_mag4_ff}) : $signed({1'b0, nz_mag4_ff});

   always_ff @(posedge clock) begin
      if (en5) begin
         pos_x_ff  <= pos_x_in;
         pos_y_ff  <= pos_y_in;
         pos_z_ff  <= pos_z_in;
         norm_x_ff <= norm_x_in;
         norm_y_ff <= norm_y_in;
         norm_z_ff <= norm_z_in;
         tex_s_ff  <= tex_s4_ff;
         tex_t_ff  <= tex_t4_ff;
      end
   end

   assign rsp_pos_x  = pos_x_ff;
   assign rsp_pos_y  = pos_y_ff;
   assign rsp_pos_z  = pos_z_ff;
   assign rsp_norm_x = norm_x_ff;
   assign rsp_norm_y = norm_y_ff;
   assign rsp_norm_z = norm_z_ff;
   assign rsp_tex_s  = tex_s_ff;
   assign rsp_tex_t  = tex_t_ff;

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   // Back-pressure reaches the request side only with every stage occupied
   a_full_before_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (v1_ff && v2_ff && v3_ff && v4_ff && v5_ff))
      else $error("request stalled with a free pipeline stage");

   // A word in stage 4 is never dropped while the output is held
   a_hold_stage4: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && !en4) |=> v4_ff)
      else $error("stage 4 word lost during stall");

   a_tex_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_tex_s <= TEX_ONE && rsp_tex_t <= TEX_ONE))
      else $error("texture coordinate above 1.0");

   a_norm_z_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_norm_z <= 16'sd16384 && rsp_norm_z >= -16'sd16384))
      else $error("normal z outside unit range");

endmodule

`default_nettype wire
